// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: soft timer scheduler package
// shared constants, state and handshake types for the timer scheduler
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int NUM_TIMERS       = 8;
  localparam int TICKS_PER_SECOND = 100;

  localparam int HW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW    = 7;
  localparam int SW    = 32;
  localparam int IVW   = 16;
  localparam int HDLW  = 8;
  localparam int FHW   = 3;

  // reciprocal of the tick rate, exact floor for any 16-bit interval
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam int PW          = IVW + RECIP_SHIFT;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_WAIT,
    S_SCAN,
    S_RESCHED,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic           start;
    logic [IVW-1:0] interval;
    logic [SW-1:0]  now_sec;
    logic [TW-1:0]  now_tick;
  } sched_req_t;

  typedef struct packed {
    logic          done;
    logic [SW-1:0] dsec;
    logic [TW-1:0] dtick;
  } sched_rsp_t;

endpackage

// ===== rtl/soft_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// soft_timer_scheduler: eight-channel software timer scheduler
// keeps a 10 ms tick and seconds count, arms timers and reports expiries
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A set request that
// arms a timer runs one deadline computation in the shared three-step unit; a
// stop or an out-of-range set is answered straight from idle. A tick request
// scans the timers one after another and then gives one event per expiry; each
// repeating timer that fires is rescheduled during the scan, through the same
// unit. Every result shows on the result ports for exactly one cycle with
// strobe high and cannot be held off; last marks the final result of a request,
// and a tick on which nothing expires gives none.
module soft_timer_scheduler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode,
  input  logic [sts_pkg::HDLW-1:0]  timer_handle,
  input  logic [sts_pkg::IVW-1:0]   interval_ticks,
  input  logic                      one_shot,
  output logic                      strobe,
  output logic                      kind,
  output logic                      status,
  output logic [sts_pkg::FHW-1:0]   fired_handle,
  output logic [sts_pkg::SW-1:0]    uptime_seconds,
  output logic [sts_pkg::TW-1:0]    tick_in_second,
  output logic                      last
);

  sts_pkg::state_t state, state_next;

  logic [sts_pkg::TW-1:0]         tick_count, tick_next;
  logic [sts_pkg::SW-1:0]         second_count, second_next;
  logic [sts_pkg::NUM_TIMERS-1:0] enabled_mask, enabled_next;
  logic [sts_pkg::NUM_TIMERS-1:0] repeat_mask, repeat_next;
  logic [sts_pkg::NUM_TIMERS-1:0] match, match_next;
  logic [sts_pkg::NUM_TIMERS-1:0] match_rest;
  logic [sts_pkg::HW-1:0]         idx, idx_next;
  logic [sts_pkg::HW-1:0]         first;
  logic                           found;

  logic [sts_pkg::IVW-1:0] interval_store  [sts_pkg::NUM_TIMERS];
  logic [sts_pkg::SW-1:0]  deadline_second [sts_pkg::NUM_TIMERS];
  logic [sts_pkg::TW-1:0]  deadline_tick   [sts_pkg::NUM_TIMERS];

  logic                    iv_we;
  logic                    dl_we;
  logic                    hit;
  logic                    last_timer;

  logic                    strobe_next;
  logic                    kind_next;
  logic                    status_next;
  logic [sts_pkg::FHW-1:0] handle_next;
  logic                    last_next;

  sts_pkg::sched_req_t sreq;
  sts_pkg::sched_rsp_t srsp;

  sts_sched u_sched (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  assign busy       = state != sts_pkg::S_IDLE;
  assign hit        = enabled_mask[idx] && (deadline_second[idx] == second_count)
                      && (deadline_tick[idx] == tick_count);
  assign last_timer = idx == sts_pkg::HW'(sts_pkg::NUM_TIMERS - 1);

  // lowest pending expiry
  always_comb begin
    first = '0;
    found = 1'b0;
    for (int i = 0; i < sts_pkg::NUM_TIMERS; i++) begin
      if (match[i] && !found) begin
        first = sts_pkg::HW'(i);
        found = 1'b1;
      end
    end
    match_rest        = match;
    match_rest[first] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sts_pkg::S_IDLE;
      tick_count   <= '0;
      second_count <= '0;
      enabled_mask <= '0;
      repeat_mask  <= '0;
      match        <= '0;
      idx          <= '0;
      strobe       <= 1'b0;
    end else begin
      state        <= state_next;
      tick_count   <= tick_next;
      second_count <= second_next;
      enabled_mask <= enabled_next;
      repeat_mask  <= repeat_next;
      match        <= match_next;
      idx          <= idx_next;
      strobe       <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (iv_we) begin
      interval_store[idx_next] <= interval_ticks;
    end
    if (dl_we) begin
      deadline_second[idx] <= srsp.dsec;
      deadline_tick[idx]   <= srsp.dtick;
    end
    if (strobe_next) begin
      kind           <= kind_next;
      status         <= status_next;
      fired_handle   <= handle_next;
      last           <= last_next;
      uptime_seconds <= second_count;
      tick_in_second <= tick_count;
    end
  end

  always_comb begin
    state_next    = state;
    tick_next     = tick_count;
    second_next   = second_count;
    enabled_next  = enabled_mask;
    repeat_next   = repeat_mask;
    match_next    = match;
    idx_next      = idx;
    iv_we         = 1'b0;
    dl_we         = 1'b0;
    strobe_next   = 1'b0;
    kind_next     = sts_pkg::KIND_REPLY;
    status_next   = sts_pkg::ST_OK;
    handle_next   = '0;
    last_next     = 1'b1;
    sreq.start    = 1'b0;
    sreq.interval = (state == sts_pkg::S_IDLE) ? interval_ticks : interval_store[idx];
    sreq.now_sec  = second_count;
    sreq.now_tick = tick_count;

    unique case (state)
      sts_pkg::S_IDLE: begin
        if (start) begin
          if (opcode == sts_pkg::OP_SET) begin
            if (timer_handle >= sts_pkg::HDLW'(sts_pkg::NUM_TIMERS)) begin
              strobe_next = 1'b1;
              status_next = sts_pkg::ST_RANGE;
            end else if (interval_ticks == '0) begin
              enabled_next[timer_handle[sts_pkg::HW-1:0]] = 1'b0;
              strobe_next = 1'b1;
            end else begin
              idx_next = timer_handle[sts_pkg::HW-1:0];
              enabled_next[idx_next] = 1'b1;
              repeat_next[idx_next]  = !one_shot;
              iv_we      = 1'b1;
              sreq.start = 1'b1;
              state_next = sts_pkg::S_SET_WAIT;
            end
          end else begin
            if (tick_count == sts_pkg::TW'(sts_pkg::TICKS_PER_SECOND - 1)) begin
              tick_next   = '0;
              second_next = second_count + 32'd1;
            end else begin
              tick_next = tick_count + 7'd1;
            end
            idx_next   = '0;
            match_next = '0;
            state_next = sts_pkg::S_SCAN;
          end
        end
      end
      sts_pkg::S_SET_WAIT: begin
        if (srsp.done) begin
          dl_we       = 1'b1;
          strobe_next = 1'b1;
          state_next  = sts_pkg::S_IDLE;
        end
      end
      sts_pkg::S_SCAN: begin
        if (hit) begin
          match_next[idx] = 1'b1;
        end
        if (hit && repeat_mask[idx]) begin
          sreq.start = 1'b1;
          state_next = sts_pkg::S_RESCHED;
        end else begin
          if (hit) begin
            enabled_next[idx] = 1'b0;
          end
          if (last_timer) begin
            state_next = sts_pkg::S_EMIT;
          end else begin
            idx_next = idx + sts_pkg::HW'(1);
          end
        end
      end
      sts_pkg::S_RESCHED: begin
        if (srsp.done) begin
          dl_we = 1'b1;
          if (last_timer) begin
            state_next = sts_pkg::S_EMIT;
          end else begin
            idx_next   = idx + sts_pkg::HW'(1);
            state_next = sts_pkg::S_SCAN;
          end
        end
      end
      sts_pkg::S_EMIT: begin
        if (!found) begin
          state_next = sts_pkg::S_IDLE;
        end else begin
          strobe_next = 1'b1;
          kind_next   = sts_pkg::KIND_EVENT;
          handle_next = sts_pkg::FHW'(first);
          last_next   = match_rest == '0;
          match_next  = match_rest;
          if (match_rest == '0) begin
            state_next = sts_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = sts_pkg::S_IDLE;
      end
    endcase
  end

  // deadline unit answers only while a computation is awaited
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    srsp.done |-> (state == sts_pkg::S_SET_WAIT || state == sts_pkg::S_RESCHED))
    else $error("deadline unit done outside a wait state");

  // a reply is always the only and final result of its request
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == sts_pkg::KIND_REPLY) |-> last)
    else $error("set reply without last");

  // events carry success status and report an in-range tick
  a_event_fields: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == sts_pkg::KIND_EVENT) |->
      (status == sts_pkg::ST_OK && tick_in_second < sts_pkg::TW'(sts_pkg::TICKS_PER_SECOND)))
    else $error("malformed expiry event");

  // after the final result the block is ready again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy || $past(state == sts_pkg::S_IDLE))
    else $error("still busy after final result");

endmodule

// ===== rtl/sts_sched.sv =====
// ----------------------------------------------------------------------------
// sts_sched: deadline unit
// three-step unit computing now + interval with ticks carried into seconds
// ----------------------------------------------------------------------------
module sts_sched (
  input  logic               clk,
  input  logic               rst,
  input  sts_pkg::sched_req_t req,
  output sts_pkg::sched_rsp_t rsp
);

  logic                       va;
  logic                       vb;
  logic                       vc;
  logic [sts_pkg::IVW-1:0]    iv_a;
  logic [sts_pkg::PW-1:0]     prod_a;
  logic [sts_pkg::IVW-1:0]    q_b;
  logic [sts_pkg::TW-1:0]     rem_b;
  logic [sts_pkg::IVW-1:0]    q_a;
  logic [sts_pkg::IVW-1:0]    qm_a;
  logic [sts_pkg::TW:0]       sum_b;
  logic                       carry_b;
  logic [sts_pkg::SW-1:0]     dsec;
  logic [sts_pkg::TW-1:0]     dtick;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= req.start;
      vb <= va;
      vc <= vb;
    end
  end

  assign q_a     = prod_a[sts_pkg::RECIP_SHIFT +: sts_pkg::IVW];
  assign qm_a    = sts_pkg::IVW'(q_a * sts_pkg::IVW'(sts_pkg::TICKS_PER_SECOND));
  assign sum_b   = (sts_pkg::TW+1)'(req.now_tick) + (sts_pkg::TW+1)'(rem_b);
  assign carry_b = sum_b >= (sts_pkg::TW+1)'(sts_pkg::TICKS_PER_SECOND);

  always_ff @(posedge clk) begin
    if (req.start) begin
      iv_a   <= req.interval;
      prod_a <= sts_pkg::PW'(req.interval) * sts_pkg::PW'(sts_pkg::RECIP);
    end
    if (va) begin
      q_b   <= q_a;
      rem_b <= sts_pkg::TW'(iv_a - qm_a);
    end
    if (vb) begin
      if (carry_b) begin
        dtick <= sts_pkg::TW'(sum_b - (sts_pkg::TW+1)'(sts_pkg::TICKS_PER_SECOND));
        dsec  <= req.now_sec + sts_pkg::SW'(q_b) + 32'd1;
      end else begin
        dtick <= sts_pkg::TW'(sum_b);
        dsec  <= req.now_sec + sts_pkg::SW'(q_b);
      end
    end
  end

  assign rsp.done  = vc;
  assign rsp.dsec  = dsec;
  assign rsp.dtick = dtick;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: soft timer scheduler regression
// drives tick and set requests through the start/busy handshake, predicts the
// replies and expiry events of every accepted request and checks each strobed
// result in order, under several sender idling phases
// ----------------------------------------------------------------------------
module tb_top;
  import sts_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 64;
  localparam int RANDOM_ITEMS = 90;

  typedef struct packed {
    logic            opcode;
    logic [HDLW-1:0] handle;
    logic [IVW-1:0]  interval;
    logic            one_shot;
  } timer_req_t;

  typedef struct packed {
    logic           kind;
    logic           status;
    logic [FHW-1:0] fired;
    logic [SW-1:0]  seconds;
    logic [TW-1:0]  tick;
    logic           last;
  } timer_result_t;

  typedef struct {
    timer_req_t    req;
    bit            typed;
    timer_result_t want;
  } directed_row_t;

  localparam timer_result_t UNTYPED = '0;

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic            busy;
  logic            opcode;
  logic [HDLW-1:0] timer_handle;
  logic [IVW-1:0]  interval_ticks;
  logic            one_shot;
  logic            strobe;
  logic            kind;
  logic            status;
  logic [FHW-1:0]  fired_handle;
  logic [SW-1:0]   uptime_seconds;
  logic [TW-1:0]   tick_in_second;
  logic            last;

  // predicted scheduler state
  logic [TW-1:0]   now_tick;
  logic [SW-1:0]   now_sec;
  logic [7:0]      armed_mask;
  logic [7:0]      periodic_mask;
  logic [IVW-1:0]  timer_interval [NUM_TIMERS];
  logic [SW-1:0]   due_sec [NUM_TIMERS];
  logic [TW-1:0]   due_tick [NUM_TIMERS];

  timer_result_t   awaited_results[$];
  int              error_count = 0;
  int              cycle_count = 0;

  directed_row_t directed [24] = '{
    '{'{OP_SET, 8'd255, 16'hFFFF, 1'b1}, 1'b1, '{KIND_REPLY, ST_RANGE, 3'd0, 32'd0, 7'd0, 1'b1}},
    '{'{OP_SET, 8'd8, 16'd5, 1'b0}, 1'b1, '{KIND_REPLY, ST_RANGE, 3'd0, 32'd0, 7'd0, 1'b1}},
    '{'{OP_SET, 8'd0, 16'd1, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd0, 1'b1}},
    '{'{OP_TICK, 8'd0, 16'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SET, 8'd7, 16'hFFFF, 1'b1}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd1, 16'd100, 1'b1}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd0, 16'd0, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd0, 16'd3, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd1, 16'd3, 1'b1}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd2, 16'd3, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd3, 16'd3, 1'b1}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd4, 16'd3, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd5, 16'd3, 1'b1}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd6, 16'd3, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_SET, 8'd7, 16'd3, 1'b1}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd1, 1'b1}},
    '{'{OP_TICK, 8'd0, 16'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_TICK, 8'hAA, 16'hFFFF, 1'b1}, 1'b0, UNTYPED},
    '{'{OP_TICK, 8'd0, 16'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_TICK, 8'h55, 16'h5555, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_TICK, 8'd0, 16'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_TICK, 8'd0, 16'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SET, 8'd2, 16'd0, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd7, 1'b1}},
    '{'{OP_SET, 8'd4, 16'd199, 1'b0}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd7, 1'b1}},
    '{'{OP_SET, 8'd6, 16'd99, 1'b1}, 1'b1, '{KIND_REPLY, ST_OK, 3'd0, 32'd0, 7'd7, 1'b1}}
  };

  soft_timer_scheduler dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .timer_handle   (timer_handle),
    .interval_ticks (interval_ticks),
    .one_shot       (one_shot),
    .strobe         (strobe),
    .kind           (kind),
    .status         (status),
    .fired_handle   (fired_handle),
    .uptime_seconds (uptime_seconds),
    .tick_in_second (tick_in_second),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic rearm_timer(input int h);
    logic [SW-1:0] s;
    logic [7:0]    t;
    s = now_sec + SW'(timer_interval[h] / TICKS_PER_SECOND);
    t = {1'b0, now_tick} + 8'(timer_interval[h] % TICKS_PER_SECOND);
    if (t > 8'(TICKS_PER_SECOND - 1)) begin
      t = t - 8'(TICKS_PER_SECOND);
      s = s + 1;
    end
    due_sec[h]  = s;
    due_tick[h] = t[TW-1:0];
  endtask

  task automatic run_timer_request(input timer_req_t r, ref timer_result_t res[$]);
    logic [FHW-1:0] hs;
    res.delete();
    hs = r.handle[FHW-1:0];
    if (r.opcode == OP_SET) begin
      if (r.handle >= HDLW'(NUM_TIMERS)) begin
        res.push_back('{KIND_REPLY, ST_RANGE, 3'd0, now_sec, now_tick, 1'b1});
      end else begin
        if (r.interval == '0) begin
          armed_mask[hs] = 1'b0;
        end else begin
          armed_mask[hs]     = 1'b1;
          periodic_mask[hs]  = !r.one_shot;
          timer_interval[hs] = r.interval;
          rearm_timer(int'(hs));
        end
        res.push_back('{KIND_REPLY, ST_OK, 3'd0, now_sec, now_tick, 1'b1});
      end
    end else begin
      if (now_tick == TW'(TICKS_PER_SECOND - 1)) begin
        now_tick = '0;
        now_sec  = now_sec + 1;
      end else begin
        now_tick = now_tick + TW'(1);
      end
      for (int h = 0; h < NUM_TIMERS; h++) begin
        if (armed_mask[h] && due_sec[h] == now_sec && due_tick[h] == now_tick) begin
          if (periodic_mask[h]) rearm_timer(h);
          else armed_mask[h] = 1'b0;
          res.push_back('{KIND_EVENT, ST_OK, FHW'(h), now_sec, now_tick, 1'b0});
        end
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                 input logic [SW-1:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic send_request(input timer_req_t r, input int idle_pct, input bit drain,
                              input bit typed, input timer_result_t want);
    int            gap;
    timer_result_t produced[$];
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (drain && gap == 0) gap = 1;
    if (gap > 0) start <= 1'b0;
    repeat (gap) @(posedge clk);
    if (drain) while (awaited_results.size() != 0) @(posedge clk);
    start          <= 1'b1;
    opcode         <= r.opcode;
    timer_handle   <= r.handle;
    interval_ticks <= r.interval;
    one_shot       <= r.one_shot;
    do @(posedge clk); while (busy !== 1'b0);
    run_timer_request(r, produced);
    if (typed) awaited_results.push_back(want);
    else foreach (produced[i]) awaited_results.push_back(produced[i]);
  endtask

  function automatic timer_req_t random_request();
    timer_req_t r;
    int         pick;
    r.opcode   = ($urandom_range(99) < 62) ? OP_TICK : OP_SET;
    r.handle   = HDLW'($urandom);
    r.interval = IVW'($urandom);
    r.one_shot = 1'($urandom);
    if (r.opcode == OP_SET) begin
      pick = $urandom_range(99);
      if (pick >= 10) r.handle = HDLW'($urandom_range(NUM_TIMERS - 1, 0));
      pick = $urandom_range(99);
      if (pick < 10) r.interval = '0;
      else if (pick < 30) r.interval = IVW'($urandom_range(400, 100));
      else if (pick >= 40) r.interval = IVW'($urandom_range(120, 1));
    end
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && strobe !== 1'b0) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result strobe", SW'(strobe), 0);
      end else begin
        want = awaited_results.pop_front();
        if (strobe !== 1'b1) report_mismatch("strobe", SW'(strobe), 1);
        if (kind !== want.kind) report_mismatch("kind", SW'(kind), SW'(want.kind));
        if (status !== want.status) report_mismatch("status", SW'(status), SW'(want.status));
        if (fired_handle !== want.fired)
          report_mismatch("fired_handle", SW'(fired_handle), SW'(want.fired));
        if (uptime_seconds !== want.seconds)
          report_mismatch("uptime_seconds", uptime_seconds, want.seconds);
        if (tick_in_second !== want.tick)
          report_mismatch("tick_in_second", SW'(tick_in_second), SW'(want.tick));
        if (last !== want.last) report_mismatch("last", SW'(last), SW'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int idle_pct [4];
    idle_pct       = '{0, 67, 0, 12};
    rst            <= 1'b1;
    start          <= 1'b0;
    opcode         <= OP_TICK;
    timer_handle   <= '0;
    interval_ticks <= '0;
    one_shot       <= 1'b0;
    now_tick       = '0;
    now_sec        = '0;
    armed_mask     = '0;
    periodic_mask  = '0;
    for (int h = 0; h < NUM_TIMERS; h++) begin
      timer_interval[h] = '0;
      due_sec[h]        = '0;
      due_tick[h]       = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_request(directed[i].req, 0, 1'b0, directed[i].typed, directed[i].want);

    // random requests in idling phases; drain before the first and third
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < RANDOM_ITEMS; n++)
        send_request(random_request(), idle_pct[phase], n == 0 && phase[0] == 1'b0, 1'b0,
                     UNTYPED);
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
